[rtl/srsw_pkg.sv]
// Shared types and constants for the selective-repeat send window.
// No dependencies; every other file of the block imports this package.
package srsw_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Request kinds of a result beat.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SEND   = 2'd1;
    localparam logic [1:0] KIND_RESEND = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd1;

    localparam logic [5:0]  WINDOW_RESET  = 6'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] last_seq;
        logic [15:0] ack_seq;
        logic        ack_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [15:0] request_seq;
        logic [16:0] oldest_unacked;
        logic        transfer_done;
        logic        last_of_run;
    } t_result;

    // Classified work passed from the front to the back.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] seq_arg;
        logic        ack_ok;
    } t_work;

endpackage

[rtl/srsw_front.sv]
// Front end of the send window: accepts command beats, classifies them and
// queues them for the back end. Depends on srsw_pkg.
module srsw_front import srsw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    output logic     o_busy,
    output t_work    o_head,
    output logic     o_head_vld,
    input  logic     i_pop
);

    t_work      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_work      w_cls;

    // Start carries the last sequence, an ack carries the acked sequence.
    always_comb begin
        w_cls.op      = i_item.command;
        w_cls.seq_arg = (i_item.command == CMD_START) ? i_item.last_seq : i_item.ack_seq;
        w_cls.ack_ok  = i_item.ack_valid;
    end

    assign o_busy     = (r_cnt == 2'd2);
    assign w_push     = i_start && !o_busy;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_head     = r_q[r_rp];
    assign o_head_vld = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cls;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2)) else $error("queue overfilled");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("queue pointers");

endmodule

[rtl/srsw_back.sv]
// Back end of the send window: executes start, ack and tick work, owns the
// slot marks, the stamp memory and the result register. Depends on srsw_pkg.
module srsw_back import srsw_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_work       i_head,
    input  logic        i_head_vld,
    output logic        o_pop,
    input  logic [5:0]  i_window_size,
    input  logic [15:0] i_timeout_ticks,
    output logic        o_strobe,
    output t_result     o_result
);

    localparam int SW   = $clog2(RING_DEPTH);
    localparam int LIM  = (RING_DEPTH < 32) ? RING_DEPTH : 32;
    localparam int SUMW = ((SW > 6) ? SW : 6) + 1;
    localparam int AW   = (TIME_BITS > 16) ? TIME_BITS : 16;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DISP = 6'b000010,
        ST_WALK = 6'b000100,
        ST_RD   = 6'b001000,
        ST_EV   = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state                r_state;
    t_work                 r_work;
    logic [RING_DEPTH-1:0] r_acked;
    logic [RING_DEPTH-1:0] r_sent;
    logic [16:0]           r_base;
    logic [SW-1:0]         r_base_slot;
    logic [15:0]           r_final;
    logic [TIME_BITS-1:0]  r_tick;
    logic [17:0]           r_s;
    logic [SW-1:0]         r_slot;
    logic [17:0]           r_end;
    logic                  r_pend_vld;
    logic [1:0]            r_pend_kind;
    logic [15:0]           r_pend_seq;
    logic                  r_stb;
    t_result               r_out;
    logic [TIME_BITS-1:0]  r_rd_stamp;
    logic [TIME_BITS-1:0]  r_stamps [RING_DEPTH];

    logic [5:0]            w_win;
    logic [17:0]           w_win_end;
    logic                  w_ack_in;
    logic [5:0]            w_off;
    logic [SUMW-1:0]       w_sum;
    logic [SW-1:0]         w_ack_slot;
    logic [SW-1:0]         w_slot_inc;
    logic [TIME_BITS-1:0]  w_age;
    logic                  w_expired;
    logic                  w_scan_more;
    logic                  w_wr;
    logic [1:0]            w_new_kind;

    always_comb begin
        if (i_window_size == 6'd0) begin
            w_win = 6'd1;
        end else if (i_window_size > 6'(LIM)) begin
            w_win = 6'(LIM);
        end else begin
            w_win = i_window_size;
        end
    end

    assign w_win_end  = {1'b0, r_base} + {12'd0, w_win};
    assign w_ack_in   = r_work.ack_ok && ({2'b0, r_work.seq_arg} >= {1'b0, r_base})
                        && ({2'b0, r_work.seq_arg} < w_win_end) && (r_work.seq_arg <= r_final);
    assign w_off      = 6'(r_work.seq_arg - r_base[15:0]);
    assign w_sum      = SUMW'(r_base_slot) + SUMW'(w_off);
    assign w_ack_slot = (w_sum >= SUMW'(RING_DEPTH)) ? SW'(w_sum - SUMW'(RING_DEPTH))
                                                      : SW'(w_sum);
    assign w_slot_inc = (r_slot == SW'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign w_age      = r_tick - r_rd_stamp;
    assign w_expired  = AW'(w_age) >= AW'(i_timeout_ticks);
    assign w_scan_more = (r_s < r_end) && (r_s <= {2'b0, r_final});

    always_comb begin
        w_wr       = 1'b0;
        w_new_kind = KIND_STATUS;
        if (r_state == ST_EV && !r_acked[r_slot]) begin
            if (!r_sent[r_slot]) begin
                w_wr       = 1'b1;
                w_new_kind = KIND_SEND;
            end else if (w_expired) begin
                w_wr       = 1'b1;
                w_new_kind = KIND_RESEND;
            end
        end
    end

    assign o_pop    = (r_state == ST_IDLE) && i_head_vld;
    assign o_strobe = r_stb;
    assign o_result = r_out;

    // Stamp memory: at most one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_stamps[r_slot] <= r_tick;
        end
        if (r_state == ST_RD) begin
            r_rd_stamp <= r_stamps[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acked     <= '0;
            r_sent      <= '0;
            r_base      <= '0;
            r_base_slot <= '0;
            r_final     <= '0;
            r_tick      <= '0;
            r_pend_vld  <= 1'b0;
            r_stb       <= 1'b0;
            r_work      <= '0;
            r_s         <= '0;
            r_slot      <= '0;
            r_end       <= '0;
            r_pend_kind <= KIND_STATUS;
            r_pend_seq  <= '0;
            r_out       <= '0;
        end else begin
            r_stb <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_head_vld) begin
                        r_work  <= i_head;
                        r_state <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    r_out.request_kind   <= KIND_STATUS;
                    r_out.request_seq    <= '0;
                    r_out.oldest_unacked <= r_base;
                    r_out.transfer_done  <= r_base > {1'b0, r_final};
                    r_out.last_of_run    <= 1'b1;
                    r_state              <= ST_IDLE;
                    r_stb                <= 1'b1;
                    case (r_work.op)
                        CMD_START: begin
                            r_final              <= r_work.seq_arg;
                            r_acked              <= '0;
                            r_sent               <= '0;
                            r_base               <= '0;
                            r_base_slot          <= '0;
                            r_out.oldest_unacked <= '0;
                            r_out.transfer_done  <= 1'b0;
                        end
                        CMD_ACK: begin
                            if (w_ack_in) begin
                                r_acked[w_ack_slot] <= 1'b1;
                                if ({1'b0, r_work.seq_arg} == r_base) begin
                                    r_s     <= {1'b0, r_base};
                                    r_slot  <= r_base_slot;
                                    r_end   <= w_win_end;
                                    r_stb   <= 1'b0;
                                    r_state <= ST_WALK;
                                end
                            end
                        end
                        CMD_TICK: begin
                            r_tick  <= r_tick + 1'b1;
                            r_s     <= {1'b0, r_base};
                            r_slot  <= r_base_slot;
                            r_end   <= w_win_end;
                            r_stb   <= 1'b0;
                            r_state <= ST_RD;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_WALK: begin
                    if (r_s < r_end && r_acked[r_slot]) begin
                        r_acked[r_slot] <= 1'b0;
                        r_sent[r_slot]  <= 1'b0;
                        r_s             <= r_s + 1'b1;
                        r_slot          <= w_slot_inc;
                    end else begin
                        r_base                <= r_s[16:0];
                        r_base_slot           <= r_slot;
                        r_out.request_kind    <= KIND_STATUS;
                        r_out.request_seq     <= '0;
                        r_out.oldest_unacked  <= r_s[16:0];
                        r_out.transfer_done   <= r_s > {2'b0, r_final};
                        r_out.last_of_run     <= 1'b1;
                        r_stb                 <= 1'b1;
                        r_state               <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    r_state <= w_scan_more ? ST_EV : ST_FIN;
                end
                ST_EV: begin
                    // A request is held back one step so the last one can be flagged.
                    if (w_wr) begin
                        r_sent[r_slot] <= 1'b1;
                        if (r_pend_vld) begin
                            r_out.request_kind   <= r_pend_kind;
                            r_out.request_seq    <= r_pend_seq;
                            r_out.oldest_unacked <= r_base;
                            r_out.transfer_done  <= r_base > {1'b0, r_final};
                            r_out.last_of_run    <= 1'b0;
                            r_stb                <= 1'b1;
                        end
                        r_pend_vld  <= 1'b1;
                        r_pend_kind <= w_new_kind;
                        r_pend_seq  <= r_s[15:0];
                    end
                    r_s     <= r_s + 1'b1;
                    r_slot  <= w_slot_inc;
                    r_state <= ST_RD;
                end
                ST_FIN: begin
                    r_out.request_kind   <= r_pend_vld ? r_pend_kind : KIND_STATUS;
                    r_out.request_seq    <= r_pend_vld ? r_pend_seq : 16'd0;
                    r_out.oldest_unacked <= r_base;
                    r_out.transfer_done  <= r_base > {1'b0, r_final};
                    r_out.last_of_run    <= 1'b1;
                    r_stb                <= 1'b1;
                    r_pend_vld           <= 1'b0;
                    r_state              <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_base_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= {1'b0, r_final} + 17'd1) else $error("window base past final");
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld) else $error("pending request left over");
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_stb && r_out.last_of_run)) else $error("run not closed");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_DISP)) else $error("pop without dispatch");

endmodule

[rtl/selective_repeat_send_window.sv]
// Selective-repeat send window. Command beats (start, ack, tick) are taken
// whenever o_busy is low; a two-entry queue holds them until the executing
// back end is free, so o_busy rises only while two beats are waiting. Each
// beat yields one or more result beats on o_strobe/o_result, the last with
// last_of_run set; the receiver cannot stall them, they appear one per cycle
// at most. Steps per beat in the back end: start and ignored commands pass
// through idle and dispatch; an ack that moves the base then walks the freed
// slots in turn; a tick walks the clamped window slot by slot, each slot first
// reading the stamp memory, then checking the age and restamping.
// There is no clearing pass: the slot marks are flip-flops cleared at reset.
// Configuration is written through its own valid/ready port, always ready,
// and must only be changed while no work is in flight.
// Depends on srsw_pkg, srsw_front and srsw_back.
module selective_repeat_send_window import srsw_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int TIME_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [5:0]  r_window_size;
    logic [15:0] r_timeout_ticks;
    t_work       w_head;
    logic        w_head_vld;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= WINDOW_RESET;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_SIZE: r_window_size   <= i_cfg_data[5:0];
                CFG_TIMEOUT:     r_timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    srsw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .o_head     (w_head),
        .o_head_vld (w_head_vld),
        .i_pop      (w_pop)
    );

    srsw_back #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_vld      (w_head_vld),
        .o_pop           (w_pop),
        .i_window_size   (r_window_size),
        .i_timeout_ticks (r_timeout_ticks),
        .o_strobe        (o_strobe),
        .o_result        (o_result)
    );

endmodule
